// File: rtl/dmmu_pkg.sv
// ============================================================================
// dmmu_pkg
// Shared constants, types and address helpers for the two-level demand
// paging MMU: geometry, memory word formats and write-port structs.
// ============================================================================
`timescale 1ns / 1ps

package dmmu_pkg;

    // Address geometry and physical frame count
    localparam int DIR_BITS    = 10;
    localparam int TABLE_BITS  = 10;
    localparam int OFFSET_BITS = 12;
    localparam int FRAMES      = 1024;

    // Fixed port widths
    localparam int VADDR_W = 32;
    localparam int DATA_W  = 8;
    localparam int PADDR_W = 22;
    localparam int CNT_W   = 32;

    // Derived sizes
    localparam int     DIR_DEPTH   = 1 << DIR_BITS;
    localparam int     ENT_AW      = DIR_BITS + TABLE_BITS;
    localparam longint ENT_DEPTH   = longint'(1) << ENT_AW;
    localparam int     FRAME_W     = $clog2(FRAMES);
    localparam int     NFF_W       = $clog2(FRAMES + 1);
    localparam int     PA_W        = FRAME_W + OFFSET_BITS;
    localparam longint STORE_DEPTH = longint'(FRAMES) << OFFSET_BITS;

    // Clearing sweep covers the largest memory
    localparam longint CLR_LEN_A = (ENT_DEPTH > longint'(DIR_DEPTH)) ?
                                   ENT_DEPTH : longint'(DIR_DEPTH);
    localparam longint CLR_LEN   = (STORE_DEPTH > CLR_LEN_A) ? STORE_DEPTH : CLR_LEN_A;
    localparam int     CLR_W     = $clog2(CLR_LEN);

    // Request opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_STORE = 1'b1;

    typedef logic [DIR_BITS-1:0]    dir_idx_t;
    typedef logic [TABLE_BITS-1:0]  tbl_idx_t;
    typedef logic [OFFSET_BITS-1:0] off_t;
    typedef logic [ENT_AW-1:0]      ent_idx_t;
    typedef logic [FRAME_W-1:0]     frame_t;
    typedef logic [PA_W-1:0]        pa_t;
    typedef logic [DATA_W-1:0]      byte_t;

    // Page table entry word
    typedef struct packed {
        logic   valid;
        frame_t frame;
    } ent_word_t;

    // Page table write port (directory and entry memories)
    typedef struct packed {
        logic      dir_we;
        dir_idx_t  dir_addr;
        logic      dir_bit;
        logic      ent_we;
        ent_idx_t  ent_addr;
        ent_word_t ent_word;
    } ptab_wr_t;

    // Byte store access
    typedef struct packed {
        logic  en;
        logic  we;
        pa_t   addr;
        byte_t data;
    } store_req_t;

    // Control state, one-hot
    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_LOOK  = 4'b0100,
        ST_DATA  = 4'b1000
    } state_t;

    // Split a virtual address; bits above the fields are ignored
    function automatic dir_idx_t va_dir(input logic [VADDR_W-1:0] va);
        logic [63:0] v;
        v = 64'(va);
        return dir_idx_t'(v >> (TABLE_BITS + OFFSET_BITS));
    endfunction

    function automatic tbl_idx_t va_tbl(input logic [VADDR_W-1:0] va);
        logic [63:0] v;
        v = 64'(va);
        return tbl_idx_t'(v >> OFFSET_BITS);
    endfunction

    function automatic off_t va_off(input logic [VADDR_W-1:0] va);
        logic [63:0] v;
        v = 64'(va);
        return off_t'(v);
    endfunction

endpackage

// File: rtl/dmmu_ptab.sv
// ============================================================================
// dmmu_ptab
// Page table storage: a directory memory with one present bit per table and
// an entry memory with a valid bit and frame number per page. One read port
// and one write port each, read data registered.
// ============================================================================
`timescale 1ns / 1ps

module dmmu_ptab import dmmu_pkg::*; (
    input  logic      aclk,
    input  logic      rd_en,
    input  dir_idx_t  rd_dir,
    input  ent_idx_t  rd_ent,
    input  ptab_wr_t  wr,
    output logic      rd_dir_bit,
    output ent_word_t rd_ent_word
);

    logic      dir_mem [0:DIR_DEPTH-1];
    ent_word_t ent_mem [0:ENT_DEPTH-1];

    logic      dir_q_reg;
    ent_word_t ent_q_reg;

    // Directory: write present bit, read on lookup
    always_ff @(posedge aclk) begin
        if (wr.dir_we) begin
            dir_mem[wr.dir_addr] <= wr.dir_bit;
        end
        if (rd_en) begin
            dir_q_reg <= dir_mem[rd_dir];
        end
    end

    // Entries: write on allocation or clear, read on lookup
    always_ff @(posedge aclk) begin
        if (wr.ent_we) begin
            ent_mem[wr.ent_addr] <= wr.ent_word;
        end
        if (rd_en) begin
            ent_q_reg <= ent_mem[rd_ent];
        end
    end

    assign rd_dir_bit  = dir_q_reg;
    assign rd_ent_word = ent_q_reg;

endmodule

// File: rtl/dmmu_bstore.sv
// ============================================================================
// dmmu_bstore
// Physical byte store: single-port synchronous memory, one byte per address,
// read data registered and held between reads.
// ============================================================================
`timescale 1ns / 1ps

module dmmu_bstore import dmmu_pkg::*; (
    input  logic       aclk,
    input  store_req_t req,
    output byte_t      rdata
);

    byte_t mem [0:STORE_DEPTH-1];
    byte_t rdata_reg;

    // Write or read one byte per cycle
    always_ff @(posedge aclk) begin
        if (req.en) begin
            if (req.we) begin
                mem[req.addr] <= req.data;
            end else begin
                rdata_reg <= mem[req.addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/two_level_demand_paging_mmu_unit.sv
// ============================================================================
// two_level_demand_paging_mmu_unit
// Result path: the page table read is registered on the transfer edge, then the
// lookup allocates and accesses the byte store, then the result register loads
// once the output is free. A new request is taken only after the result loads.
// Reset: a clearing sweep over CLR_LEN addresses (4194304 by default) zeroes the
// page table and byte store; s_ready stays low until it finishes.
// ============================================================================
`timescale 1ns / 1ps

module two_level_demand_paging_mmu_unit import dmmu_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_opcode,
    input  logic [VADDR_W-1:0]  s_vaddr,
    input  logic [DATA_W-1:0]   s_wdata,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [DATA_W-1:0]   m_rdata,
    output logic [PADDR_W-1:0]  m_paddr,
    output logic                m_was_hit,
    output logic                m_new_table,
    output logic                m_new_page,
    output logic                m_out_of_memory,
    output logic [CNT_W-1:0]    m_hits_total,
    output logic [CNT_W-1:0]    m_misses_total
);

    state_t state_reg, state_next;
    logic [CLR_W-1:0] clr_cnt_reg, clr_cnt_next;

    // Request held across lookup
    logic     op_reg;
    dir_idx_t dir_reg;
    ent_idx_t ent_reg;
    off_t     off_reg;
    byte_t    wdata_reg;

    // Lookup outcome
    logic hit_reg, nt_reg, np_reg, oom_reg;
    pa_t  pa_reg;

    logic [NFF_W-1:0] nff_reg, nff_next;
    logic [CNT_W-1:0] hit_cnt_reg, hit_cnt_next;
    logic [CNT_W-1:0] miss_cnt_reg, miss_cnt_next;

    // Output register
    logic                m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]   m_rdata_reg;
    logic [PADDR_W-1:0]  m_paddr_reg;
    logic                m_was_hit_reg, m_new_table_reg, m_new_page_reg, m_oom_reg;
    logic [CNT_W-1:0]    m_hits_reg, m_misses_reg;

    logic       accept;
    logic       out_load;
    logic       rd_dir_bit;
    ent_word_t  rd_ent_word;
    byte_t      store_rdata;
    ptab_wr_t   ptab_wr;
    store_req_t store_req;

    logic   tab_ok, hit_now, oom_now;
    frame_t frame_now;
    pa_t    pa_now;
    logic   clr_dir_fit, clr_ent_fit, clr_store_fit, clr_done;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_load = (state_reg == ST_DATA) && (!m_valid_reg || m_ready);

    // Lookup decision from registered memory data
    assign tab_ok    = rd_dir_bit;
    assign hit_now   = tab_ok && rd_ent_word.valid;
    assign oom_now   = !hit_now && (nff_reg >= NFF_W'(FRAMES));
    assign frame_now = hit_now ? rd_ent_word.frame : FRAME_W'(nff_reg);
    assign pa_now    = {frame_now, off_reg};

    // Clearing sweep coverage per memory
    assign clr_dir_fit   = {1'b0, clr_cnt_reg} < (CLR_W+1)'(DIR_DEPTH);
    assign clr_ent_fit   = {1'b0, clr_cnt_reg} < (CLR_W+1)'(ENT_DEPTH);
    assign clr_store_fit = {1'b0, clr_cnt_reg} < (CLR_W+1)'(STORE_DEPTH);
    assign clr_done      = clr_cnt_reg == CLR_W'(CLR_LEN - 1);

    // Page table write port: clear during sweep, allocate on a miss with a free frame
    always_comb begin
        ptab_wr = '0;
        if (state_reg == ST_CLEAR) begin
            ptab_wr.dir_we   = clr_dir_fit;
            ptab_wr.dir_addr = dir_idx_t'(clr_cnt_reg);
            ptab_wr.dir_bit  = 1'b0;
            ptab_wr.ent_we   = clr_ent_fit;
            ptab_wr.ent_addr = ent_idx_t'(clr_cnt_reg);
        end else if (state_reg == ST_LOOK && !hit_now && !oom_now) begin
            ptab_wr.dir_we         = !tab_ok;
            ptab_wr.dir_addr       = dir_reg;
            ptab_wr.dir_bit        = 1'b1;
            ptab_wr.ent_we         = 1'b1;
            ptab_wr.ent_addr       = ent_reg;
            ptab_wr.ent_word.valid = 1'b1;
            ptab_wr.ent_word.frame = FRAME_W'(nff_reg);
        end
    end

    // Byte store access: clear during sweep, load or store after lookup unless out of memory
    always_comb begin
        store_req = '0;
        if (state_reg == ST_CLEAR) begin
            store_req.en   = clr_store_fit;
            store_req.we   = 1'b1;
            store_req.addr = pa_t'(clr_cnt_reg);
        end else if (state_reg == ST_LOOK && !oom_now) begin
            store_req.en   = 1'b1;
            store_req.we   = (op_reg == OP_STORE);
            store_req.addr = pa_now;
            store_req.data = wdata_reg;
        end
    end

    dmmu_ptab u_ptab (
        .aclk        (aclk),
        .rd_en       (accept),
        .rd_dir      (va_dir(s_vaddr)),
        .rd_ent      ({va_dir(s_vaddr), va_tbl(s_vaddr)}),
        .wr          (ptab_wr),
        .rd_dir_bit  (rd_dir_bit),
        .rd_ent_word (rd_ent_word)
    );

    dmmu_bstore u_bstore (
        .aclk  (aclk),
        .req   (store_req),
        .rdata (store_rdata)
    );

    // Sequencer and counter updates
    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        nff_next      = nff_reg;
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        m_valid_next  = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (!oom_now) begin
                    if (hit_now) begin
                        hit_cnt_next = hit_cnt_reg + 1'b1;
                    end else begin
                        nff_next      = nff_reg + 1'b1;
                        miss_cnt_next = miss_cnt_reg + 1'b1;
                    end
                end
                state_next = ST_DATA;
            end
            ST_DATA: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            nff_reg      <= '0;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            nff_reg      <= nff_next;
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Capture request on transfer
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg    <= s_opcode;
            dir_reg   <= va_dir(s_vaddr);
            ent_reg   <= {va_dir(s_vaddr), va_tbl(s_vaddr)};
            off_reg   <= va_off(s_vaddr);
            wdata_reg <= s_wdata;
        end
    end

    // Hold lookup outcome for the result stage
    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOOK) begin
            hit_reg <= hit_now && !oom_now;
            nt_reg  <= !hit_now && !oom_now && !tab_ok;
            np_reg  <= !hit_now && !oom_now;
            oom_reg <= oom_now;
            pa_reg  <= pa_now;
        end
    end

    // Load result register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_rdata_reg     <= (oom_reg || op_reg == OP_STORE) ? '0 : store_rdata;
            m_paddr_reg     <= oom_reg ? '0 : PADDR_W'(pa_reg);
            m_was_hit_reg   <= hit_reg;
            m_new_table_reg <= nt_reg;
            m_new_page_reg  <= np_reg;
            m_oom_reg       <= oom_reg;
            m_hits_reg      <= hit_cnt_reg;
            m_misses_reg    <= miss_cnt_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_rdata         = m_rdata_reg;
    assign m_paddr         = m_paddr_reg;
    assign m_was_hit       = m_was_hit_reg;
    assign m_new_table     = m_new_table_reg;
    assign m_new_page      = m_new_page_reg;
    assign m_out_of_memory = m_oom_reg;
    assign m_hits_total    = m_hits_reg;
    assign m_misses_total  = m_misses_reg;

`ifndef ASSERT_OFF
    // Frame allocation never runs past the physical store
    a_nff_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        nff_reg <= NFF_W'(FRAMES))
        else $error("free frame pointer beyond frame count");

    // A transfer walks lookup then result stage
    a_walk_order: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_LOOK) ##1 (state_reg == ST_DATA))
        else $error("request did not advance through lookup");

    // A new result comes only out of the result stage
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !$past(m_valid_reg)) |-> $past(state_reg == ST_DATA))
        else $error("result raised outside result stage");

    // Miss count moves only together with a frame allocation
    a_miss_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOOK) |=>
            ((miss_cnt_reg != $past(miss_cnt_reg)) == (nff_reg != $past(nff_reg))))
        else $error("miss count and frame allocation out of step");
`endif

endmodule
